// ===== rtl/core/pfp_pkg.sv =====
// ----------------------------------------------------------------------------
// pfp_pkg: shared types and constants for the plane-from-three-points core
// Beat layouts of both channels and of the internal pipeline hand-offs,
// together with the fixed-point widths used along the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pfp_pkg;

  // Point coordinates are signed Q15.8.
  localparam int unsigned CoordW  = 24;
  // Edge vectors: difference of two coordinates.
  localparam int unsigned EdgeW   = CoordW + 1;
  // One partial product of the cross product.
  localparam int unsigned ProdW   = 2 * EdgeW;
  // A cross product component and its magnitude.
  localparam int unsigned CrossW  = ProdW + 1;
  localparam int unsigned MagW    = ProdW;
  // Bit length of the largest magnitude, 0 to MagW.
  localparam int unsigned BlW     = $clog2(MagW + 1);
  // The largest normalized magnitude lies in [2^29, 2^30); the others lie below 2^30.
  localparam int unsigned NrmBits = 30;
  // Sum of the three normalized squares.
  localparam int unsigned SumW    = 2 * NrmBits + 2;
  // Integer square root of that sum.
  localparam int unsigned RootW   = SumW / 2;
  // Fraction bits of the unit normal (Q1.14) and quotient width.
  localparam int unsigned FracW   = 14;
  localparam int unsigned QuotW   = FracW + 1;
  localparam int unsigned RemW    = NrmBits + FracW + 2;
  // Output widths.
  localparam int unsigned NrmW    = 16;
  localparam int unsigned DistW   = 24;
  // Threshold register and its square.
  localparam int unsigned LenW    = 16;
  localparam int unsigned ThrW    = 2 * LenW;
  localparam logic [LenW-1:0] MinLengthReset = LenW'(66);

  // Register file of the configuration port.
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned RegIdxW  = PaddrW - 2;
  localparam logic [RegIdxW-1:0] RegMinLength = RegIdxW'(0);

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t p0_x;
    coord_t p0_y;
    coord_t p0_z;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p1_z;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p2_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [NrmW-1:0]  normal_x;
    logic signed [NrmW-1:0]  normal_y;
    logic signed [NrmW-1:0]  normal_z;
    logic signed [DistW-1:0] plane_distance;
    logic                    degenerate;
  } out_beat_t;

  // Front end to square root unit.
  typedef struct packed {
    logic [SumW-1:0]              sum;
    logic [2:0][NrmBits-1:0]      mag;
    logic [2:0]                   neg;
    logic                         degen;
    logic [2:0][CoordW-1:0]       p0;
  } sq_beat_t;

  // Square root unit to divider.
  typedef struct packed {
    logic [RootW-1:0]             len;
    logic [2:0][NrmBits-1:0]      mag;
    logic [2:0]                   neg;
    logic                         degen;
    logic [2:0][CoordW-1:0]       p0;
  } dv_beat_t;

  // Divider to distance stages.
  typedef struct packed {
    logic [2:0][NrmW-1:0]         nrm;
    logic                         degen;
    logic [2:0][CoordW-1:0]       p0;
  } nrm_beat_t;

endpackage

`default_nettype wire

// ===== rtl/core/pfp_front.sv =====
// ----------------------------------------------------------------------------
// pfp_front: edges, cross product, degenerate test and normalization
// Eight register stages from the three points to the sum of the squared,
// normalized cross product components.
// ----------------------------------------------------------------------------
`default_nettype none

module pfp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  pfp_pkg::in_beat_t     beat_i,
  input  logic [pfp_pkg::ThrW-1:0] thr_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output pfp_pkg::sq_beat_t     beat_o
);
  import pfp_pkg::*;

  localparam int unsigned Stages = 8;

  logic [Stages-1:0] v_q;
  logic [Stages-1:0] v_d;
  logic [Stages:0]   rdy;

  assign rdy[Stages] = !stall_i;
  for (genvar k = 0; k < Stages; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign v_d = {v_q[Stages-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  assign stall_o = !rdy[0];
  assign valid_o = v_q[Stages-1];

  // First point travels alongside the arithmetic.
  logic [2:0][CoordW-1:0] p0_d;
  logic [2:0][CoordW-1:0] p0_q [Stages-1];

  assign p0_d = {beat_i.p0_z, beat_i.p0_y, beat_i.p0_x};

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      p0_q[0] <= p0_d;
    end
    for (int k = 1; k < Stages - 1; k++) begin
      if (rdy[k]) begin
        p0_q[k] <= p0_q[k-1];
      end
    end
  end

  // Stage 0: edge vectors.
  logic signed [EdgeW-1:0] e1_d [3];
  logic signed [EdgeW-1:0] e2_d [3];
  logic signed [EdgeW-1:0] e1_q [3];
  logic signed [EdgeW-1:0] e2_q [3];

  always_comb begin
    e1_d[0] = EdgeW'(beat_i.p1_x) - EdgeW'(beat_i.p0_x);
    e1_d[1] = EdgeW'(beat_i.p1_y) - EdgeW'(beat_i.p0_y);
    e1_d[2] = EdgeW'(beat_i.p1_z) - EdgeW'(beat_i.p0_z);
    e2_d[0] = EdgeW'(beat_i.p2_x) - EdgeW'(beat_i.p0_x);
    e2_d[1] = EdgeW'(beat_i.p2_y) - EdgeW'(beat_i.p0_y);
    e2_d[2] = EdgeW'(beat_i.p2_z) - EdgeW'(beat_i.p0_z);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      e1_q <= e1_d;
      e2_q <= e2_d;
    end
  end

  // Stage 1: the six partial products of the cross product.
  logic signed [ProdW-1:0] pa_q [3];
  logic signed [ProdW-1:0] pb_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      pa_q[0] <= e1_q[1] * e2_q[2];
      pb_q[0] <= e2_q[1] * e1_q[2];
      pa_q[1] <= e1_q[2] * e2_q[0];
      pb_q[1] <= e2_q[2] * e1_q[0];
      pa_q[2] <= e1_q[0] * e2_q[1];
      pb_q[2] <= e2_q[0] * e1_q[1];
    end
  end

  // Stage 2: cross product components.
  logic signed [CrossW-1:0] c_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        c_q[i] <= CrossW'(pa_q[i]) - CrossW'(pb_q[i]);
      end
    end
  end

  // Stage 3: sign and magnitude.
  logic [2:0][MagW-1:0] s3_mag_d;
  logic [2:0][MagW-1:0] s3_mag_q;
  logic [2:0]           s3_neg_q;

  always_comb begin
    logic signed [CrossW-1:0] a;
    for (int i = 0; i < 3; i++) begin
      a = c_q[i][CrossW-1] ? -c_q[i] : c_q[i];
      s3_mag_d[i] = a[MagW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s3_mag_q <= s3_mag_d;
      for (int i = 0; i < 3; i++) begin
        s3_neg_q[i] <= c_q[i][CrossW-1];
      end
    end
  end

  // Stage 4: bit length of the largest magnitude, small-case squares.
  logic [MagW-1:0]      or_mag;
  logic [BlW-1:0]       bl_d;
  logic [2:0][MagW-1:0] s4_mag_q;
  logic [2:0]           s4_neg_q;
  logic [BlW-1:0]       s4_bl_q;
  logic                 s4_small_q;
  logic [2:0][ThrW-1:0] s4_sq_q;

  assign or_mag = s3_mag_q[0] | s3_mag_q[1] | s3_mag_q[2];

  always_comb begin
    bl_d = '0;
    for (int b = 0; b < MagW; b++) begin
      if (or_mag[b]) begin
        bl_d = BlW'(b + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s4_mag_q   <= s3_mag_q;
      s4_neg_q   <= s3_neg_q;
      s4_bl_q    <= bl_d;
      s4_small_q <= (or_mag[MagW-1:LenW] == '0);
      for (int i = 0; i < 3; i++) begin
        s4_sq_q[i] <= ThrW'(s3_mag_q[i][LenW-1:0]) * ThrW'(s3_mag_q[i][LenW-1:0]);
      end
    end
  end

  // Stage 5: exact degenerate test and scaling to the normalized range.
  logic [ThrW+1:0]         sq_sum;
  logic [2:0][NrmBits-1:0] mn_d;
  logic [2:0][NrmBits-1:0] s5_mn_q;
  logic [2:0]              s5_neg_q;
  logic                    s5_degen_q;

  assign sq_sum = (ThrW+2)'(s4_sq_q[0]) + (ThrW+2)'(s4_sq_q[1]) + (ThrW+2)'(s4_sq_q[2]);

  always_comb begin
    logic [MagW+NrmBits-1:0] wide;
    for (int i = 0; i < 3; i++) begin
      wide = {s4_mag_q[i], {NrmBits{1'b0}}} >> s4_bl_q;
      mn_d[i] = wide[NrmBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      s5_mn_q    <= mn_d;
      s5_neg_q   <= s4_neg_q;
      s5_degen_q <= s4_small_q && (sq_sum <= (ThrW+2)'(thr_i));
    end
  end

  // Stage 6: squares of the normalized magnitudes.
  logic [2:0][2*NrmBits-1:0] s6_sqr_q;
  logic [2:0][NrmBits-1:0]   s6_mn_q;
  logic [2:0]                s6_neg_q;
  logic                      s6_degen_q;

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      for (int i = 0; i < 3; i++) begin
        s6_sqr_q[i] <= (2*NrmBits)'(s5_mn_q[i]) * (2*NrmBits)'(s5_mn_q[i]);
      end
      s6_mn_q    <= s5_mn_q;
      s6_neg_q   <= s5_neg_q;
      s6_degen_q <= s5_degen_q;
    end
  end

  // Stage 7: sum of squares, handed to the square root unit.
  sq_beat_t out_q;

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      out_q.sum   <= SumW'(s6_sqr_q[0]) + SumW'(s6_sqr_q[1]) + SumW'(s6_sqr_q[2]);
      out_q.mag   <= s6_mn_q;
      out_q.neg   <= s6_neg_q;
      out_q.degen <= s6_degen_q;
      out_q.p0    <= p0_q[Stages-2];
    end
  end

  assign beat_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/pfp_sqrt.sv =====
// ----------------------------------------------------------------------------
// pfp_sqrt: pipelined integer square root
// One result bit per register stage, digit-by-digit, floor of the root.
// ----------------------------------------------------------------------------
`default_nettype none

module pfp_sqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  pfp_pkg::sq_beat_t beat_i,
  output logic              valid_o,
  input  logic              stall_i,
  output pfp_pkg::dv_beat_t beat_o
);
  import pfp_pkg::*;

  localparam int unsigned Stages = RootW;

  typedef struct packed {
    logic [SumW-1:0]         x;
    logic [SumW-1:0]         res;
    logic [2:0][NrmBits-1:0] mag;
    logic [2:0]              neg;
    logic                    degen;
    logic [2:0][CoordW-1:0]  p0;
  } rt_t;

  logic [Stages-1:0] v_q;
  logic [Stages-1:0] v_d;
  logic [Stages:0]   rdy;

  assign rdy[Stages] = !stall_i;
  for (genvar k = 0; k < Stages; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign v_d = {v_q[Stages-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  assign stall_o = !rdy[0];
  assign valid_o = v_q[Stages-1];

  rt_t init;
  rt_t src  [Stages];
  rt_t nx   [Stages];
  rt_t st_q [Stages];

  always_comb begin
    init       = '0;
    init.x     = beat_i.sum;
    init.mag   = beat_i.mag;
    init.neg   = beat_i.neg;
    init.degen = beat_i.degen;
    init.p0    = beat_i.p0;
  end

  for (genvar k = 0; k < Stages; k++) begin : g_step
    localparam logic [SumW-1:0] BitV = SumW'(1) << (2 * (Stages - 1 - k));

    if (k == 0) begin : g_first
      assign src[k] = init;
    end else begin : g_next
      assign src[k] = st_q[k-1];
    end

    always_comb begin
      logic [SumW:0] trial;
      nx[k] = src[k];
      trial = {1'b0, src[k].res} + {1'b0, BitV};
      if ({1'b0, src[k].x} >= trial) begin
        nx[k].x   = src[k].x - trial[SumW-1:0];
        nx[k].res = (src[k].res >> 1) + BitV;
      end else begin
        nx[k].res = src[k].res >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Stages; k++) begin
      if (rdy[k]) begin
        st_q[k] <= nx[k];
      end
    end
  end

  assign beat_o.len   = st_q[Stages-1].res[RootW-1:0];
  assign beat_o.mag   = st_q[Stages-1].mag;
  assign beat_o.neg   = st_q[Stages-1].neg;
  assign beat_o.degen = st_q[Stages-1].degen;
  assign beat_o.p0    = st_q[Stages-1].p0;

endmodule

`default_nettype wire

// ===== rtl/core/pfp_div.sv =====
// ----------------------------------------------------------------------------
// pfp_div: pipelined rounding divider for the unit normal
// A setup stage adds half the length, one restoring quotient bit per stage
// follows, and a last stage applies sign and the degenerate override.
// ----------------------------------------------------------------------------
`default_nettype none

module pfp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  pfp_pkg::dv_beat_t  beat_i,
  output logic               valid_o,
  input  logic               stall_i,
  output pfp_pkg::nrm_beat_t beat_o
);
  import pfp_pkg::*;

  localparam int unsigned Steps  = QuotW;
  localparam int unsigned Stages = Steps + 2;

  typedef struct packed {
    logic [2:0][RemW-1:0]   rem;
    logic [2:0][QuotW-1:0]  q;
    logic [RootW-1:0]       len;
    logic [2:0]             neg;
    logic                   degen;
    logic [2:0][CoordW-1:0] p0;
  } dv_t;

  logic [Stages-1:0] v_q;
  logic [Stages-1:0] v_d;
  logic [Stages:0]   rdy;

  assign rdy[Stages] = !stall_i;
  for (genvar k = 0; k < Stages; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign v_d = {v_q[Stages-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  assign stall_o = !rdy[0];
  assign valid_o = v_q[Stages-1];

  dv_t nx   [Steps+1];
  dv_t st_q [Steps+1];

  // Setup: numerator is magnitude in Q.14 plus half the divisor.
  always_comb begin
    nx[0]       = '0;
    nx[0].len   = beat_i.len;
    nx[0].neg   = beat_i.neg;
    nx[0].degen = beat_i.degen;
    nx[0].p0    = beat_i.p0;
    for (int i = 0; i < 3; i++) begin
      nx[0].rem[i] = {2'b00, beat_i.mag[i], {FracW{1'b0}}} + RemW'(beat_i.len >> 1);
    end
  end

  for (genvar k = 1; k <= Steps; k++) begin : g_step
    localparam int unsigned B = Steps - k;

    always_comb begin
      logic [RemW-1:0] dvs;
      nx[k] = st_q[k-1];
      dvs   = RemW'(st_q[k-1].len) << B;
      for (int i = 0; i < 3; i++) begin
        if (st_q[k-1].rem[i] >= dvs) begin
          nx[k].rem[i]  = st_q[k-1].rem[i] - dvs;
          nx[k].q[i][B] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= Steps; k++) begin
      if (rdy[k]) begin
        st_q[k] <= nx[k];
      end
    end
  end

  // Last stage: signed normal, zero when degenerate.
  nrm_beat_t out_d;
  nrm_beat_t out_q;

  always_comb begin
    logic [NrmW-1:0] mq;
    out_d.degen = st_q[Steps].degen;
    out_d.p0    = st_q[Steps].p0;
    for (int i = 0; i < 3; i++) begin
      mq = NrmW'(st_q[Steps].q[i]);
      if (st_q[Steps].degen) begin
        out_d.nrm[i] = '0;
      end else if (st_q[Steps].neg[i]) begin
        out_d.nrm[i] = ~mq + NrmW'(1);
      end else begin
        out_d.nrm[i] = mq;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[Stages-1]) begin
      out_q <= out_d;
    end
  end

  assign beat_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/plane_from_three_points.sv =====
// ----------------------------------------------------------------------------
// plane_from_three_points: plane equation from three points
// Unit normal and distance of the plane through three Q15.8 points.
// ----------------------------------------------------------------------------
// The core takes one beat of three points per clock while in_stall_o is low
// and returns one beat per input beat, in order, through eight front stages
// (edges, cross product, degenerate test, normalization, squares and
// their sum), 31 square root stages that each settle one bit of the length,
// 17 divider stages (setup, one quotient bit per stage for 15 bits, sign),
// and two stages for the dot product with the first point. Every stage has
// its own valid bit, so an output stall only holds back beats that have
// nowhere to go and bubbles close up; unstalled throughput is one beat per cycle.
// The normal is Q1.14 with round half away from zero; the distance is Q15.8,
// rounded half up and saturated. When the cross product length is at or
// below min_length (register 0, byte address 0, reset 66) the plane is
// flagged degenerate and the normal and distance read as zero. The register
// may be written only while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module plane_from_three_points (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pfp_pkg::in_beat_t              in_beat_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pfp_pkg::out_beat_t             out_beat_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pfp_pkg::PaddrW-1:0]     paddr,
  input  logic [pfp_pkg::ApbDataW-1:0]   pwdata,
  output logic [pfp_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);
  import pfp_pkg::*;

  // Configuration register. The squared threshold is kept next to it so that
  // the degenerate test needs no multiplier in the datapath.
  logic [LenW-1:0]    min_length_q;
  logic [ThrW-1:0]    thr_q;
  logic [RegIdxW-1:0] reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PaddrW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q <= MinLengthReset;
      thr_q        <= ThrW'(MinLengthReset) * ThrW'(MinLengthReset);
    end else if (wr_en && (reg_idx == RegMinLength)) begin
      min_length_q <= pwdata[LenW-1:0];
      thr_q        <= ThrW'(pwdata[LenW-1:0]) * ThrW'(pwdata[LenW-1:0]);
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegMinLength: prdata = ApbDataW'(min_length_q);
      default:      prdata = '0;
    endcase
  end

  // Front end, square root and divider.
  logic      sq_valid, sq_stall;
  sq_beat_t  sq_beat;
  logic      dv_valid, dv_stall;
  dv_beat_t  dv_beat;
  logic      nr_valid, nr_stall;
  nrm_beat_t nr_beat;

  pfp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .beat_i  (in_beat_i),
    .thr_i   (thr_q),
    .valid_o (sq_valid),
    .stall_i (sq_stall),
    .beat_o  (sq_beat)
  );

  pfp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .stall_o (sq_stall),
    .beat_i  (sq_beat),
    .valid_o (dv_valid),
    .stall_i (dv_stall),
    .beat_o  (dv_beat)
  );

  pfp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_valid),
    .stall_o (dv_stall),
    .beat_i  (dv_beat),
    .valid_o (nr_valid),
    .stall_i (nr_stall),
    .beat_o  (nr_beat)
  );

  // Distance: two stages, products then sum, rounding and saturation.
  localparam int unsigned DotW   = CoordW + NrmW;
  localparam int unsigned AccW   = DotW + 2;
  localparam logic signed [AccW-1:0] RoundHalf = AccW'(1) <<< (FracW - 1);
  localparam logic signed [AccW-1:0] DistMax   = (AccW'(1) <<< (DistW - 1)) - AccW'(1);
  localparam logic signed [AccW-1:0] DistMin   = -(AccW'(1) <<< (DistW - 1));

  logic [1:0] dv_q;
  logic [2:0] d_rdy;

  assign d_rdy[2] = !out_stall_i;
  assign d_rdy[1] = !dv_q[1] || d_rdy[2];
  assign d_rdy[0] = !dv_q[0] || d_rdy[1];
  assign nr_stall = !d_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else begin
      if (d_rdy[0]) begin
        dv_q[0] <= nr_valid;
      end
      if (d_rdy[1]) begin
        dv_q[1] <= dv_q[0];
      end
    end
  end

  logic signed [DotW-1:0]  prod_q [3];
  logic signed [NrmW-1:0]  nrm_q  [3];
  logic                    degen_q;

  always_ff @(posedge clk_i) begin
    if (d_rdy[0]) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= $signed(nr_beat.p0[i]) * $signed(nr_beat.nrm[i]);
        nrm_q[i]  <= $signed(nr_beat.nrm[i]);
      end
      degen_q <= nr_beat.degen;
    end
  end

  logic signed [AccW-1:0] acc;
  logic signed [AccW-1:0] shifted;
  logic [DistW-1:0]       dist_d;
  out_beat_t              out_q;

  assign acc     = AccW'(prod_q[0]) + AccW'(prod_q[1]) + AccW'(prod_q[2]) + RoundHalf;
  assign shifted = acc >>> FracW;

  always_comb begin
    if (shifted > DistMax) begin
      dist_d = DistMax[DistW-1:0];
    end else if (shifted < DistMin) begin
      dist_d = DistMin[DistW-1:0];
    end else begin
      dist_d = shifted[DistW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_rdy[1]) begin
      out_q.normal_x       <= nrm_q[0];
      out_q.normal_y       <= nrm_q[1];
      out_q.normal_z       <= nrm_q[2];
      out_q.plane_distance <= dist_d;
      out_q.degenerate     <= degen_q;
    end
  end

  assign out_valid_o = dv_q[1];
  assign out_beat_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/pfp_checker.sv =====
// ----------------------------------------------------------------------------
// pfp_checker: port-level checks for the plane core
// Watches the result channel and the relation between its fields.
// ----------------------------------------------------------------------------
`default_nettype none

module pfp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input pfp_pkg::out_beat_t out_beat_o
);
  import pfp_pkg::*;

  localparam logic signed [NrmW-1:0] OneQ14 = NrmW'(16384);

  // A stalled result beat stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped under stall");

  // A degenerate plane reports a zero normal and zero distance.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.degenerate |->
      (out_beat_o.normal_x == '0) && (out_beat_o.normal_y == '0) &&
      (out_beat_o.normal_z == '0) && (out_beat_o.plane_distance == '0))
    else $error("degenerate result with nonzero fields");

  // Normal components never exceed one in magnitude.
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_beat_o.normal_x <= OneQ14) && (out_beat_o.normal_x >= -OneQ14) &&
      (out_beat_o.normal_y <= OneQ14) && (out_beat_o.normal_y >= -OneQ14) &&
      (out_beat_o.normal_z <= OneQ14) && (out_beat_o.normal_z >= -OneQ14))
    else $error("normal component out of range");

  // A proper plane always has a nonzero normal.
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_beat_o.degenerate |->
      (out_beat_o.normal_x != '0) || (out_beat_o.normal_y != '0) ||
      (out_beat_o.normal_z != '0))
    else $error("zero normal on a proper plane");

endmodule

bind plane_from_three_points pfp_checker u_pfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for plane_from_three_points
// Drives triangles with random gaps, stalls and register writes, predicts the
// unit normal and distance of each beat, and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class plane_scoreboard;
  pfp_pkg::out_beat_t planes_due[$];
  int errors;
  logic [15:0] min_len;

  function new();
    errors = 0;
    min_len = pfp_pkg::MinLengthReset;
  endfunction

  // Magnitudes are at most 2^49, so their squares need a wider type.
  static function logic [127:0] root_of(logic [127:0] x);
    logic [127:0] res, bit_w;
    res = 0;
    bit_w = 128'd1 << 126;
    while (bit_w > x) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (x >= res + bit_w) begin
        x = x - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function pfp_pkg::out_beat_t plane_of(pfp_pkg::in_beat_t b);
    longint p0[3], e1[3], e2[3], c[3], nrm[3], dot, d;
    logic [127:0] mg[3], mx, sq, len, q;
    int j, k, bl;
    bit degen;
    pfp_pkg::out_beat_t r;
    p0[0] = b.p0_x; p0[1] = b.p0_y; p0[2] = b.p0_z;
    e1[0] = longint'(b.p1_x) - p0[0];
    e1[1] = longint'(b.p1_y) - p0[1];
    e1[2] = longint'(b.p1_z) - p0[2];
    e2[0] = longint'(b.p2_x) - p0[0];
    e2[1] = longint'(b.p2_y) - p0[1];
    e2[2] = longint'(b.p2_z) - p0[2];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      c[i] = e1[j] * e2[k] - e2[j] * e1[k];
      mg[i] = c[i] < 0 ? -c[i] : c[i];
      if (mg[i] > mx) mx = mg[i];
      nrm[i] = 0;
    end
    sq = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
    degen = (mx < 65536) && (sq <= 128'(min_len) * min_len);
    if (!degen) begin
      bl = 0;
      while ((mx >> bl) != 0) bl++;
      // Common shift brings the largest magnitude into [2^29, 2^30).
      for (int i = 0; i < 3; i++)
        mg[i] = bl > 30 ? mg[i] >> (bl - 30) : mg[i] << (30 - bl);
      len = root_of(mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2]);
      for (int i = 0; i < 3; i++) begin
        q = (mg[i] * 16384 + (len >> 1)) / len;
        if (q > 16384) q = 16384;
        nrm[i] = c[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
    dot = p0[0] * nrm[0] + p0[1] * nrm[1] + p0[2] * nrm[2] + 8192;
    d = dot >>> 14;
    if (d > 8388607) d = 8388607;
    if (d < -8388608) d = -8388608;
    r.normal_x = 16'(nrm[0]);
    r.normal_y = 16'(nrm[1]);
    r.normal_z = 16'(nrm[2]);
    r.plane_distance = 24'(d);
    r.degenerate = degen;
    return r;
  endfunction

  function void note_triangle(pfp_pkg::in_beat_t b);
    planes_due.push_back(plane_of(b));
  endfunction

  function void check_plane(pfp_pkg::out_beat_t got);
    pfp_pkg::out_beat_t want;
    if (planes_due.size() == 0) begin
      $display("%0t: unexpected plane %h", $time, got);
      errors++;
      return;
    end
    want = planes_due.pop_front();
    if (got.normal_x !== want.normal_x) begin
      $display("%0t: normal_x expected %0d actual %0d", $time, want.normal_x, got.normal_x);
      errors++;
    end
    if (got.normal_y !== want.normal_y) begin
      $display("%0t: normal_y expected %0d actual %0d", $time, want.normal_y, got.normal_y);
      errors++;
    end
    if (got.normal_z !== want.normal_z) begin
      $display("%0t: normal_z expected %0d actual %0d", $time, want.normal_z, got.normal_z);
      errors++;
    end
    if (got.plane_distance !== want.plane_distance) begin
      $display("%0t: plane_distance expected %0d actual %0d", $time,
               want.plane_distance, got.plane_distance);
      errors++;
    end
    if (got.degenerate !== want.degenerate) begin
      $display("%0t: degenerate expected %0b actual %0b", $time,
               want.degenerate, got.degenerate);
      errors++;
    end
  endfunction
endclass

module tb;
  import pfp_pkg::*;

  localparam int unsigned Latency = 58;
  localparam int unsigned IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_beat_t in_beat_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  out_beat_t out_beat_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  plane_scoreboard planes = new();
  bit hold_off = 1'b0;     // Requests one long receiver stall.
  int unsigned idle_cycles = 0;

  plane_from_three_points u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_beat_i,
    .out_valid_o, .out_stall_i, .out_beat_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sends one triangle and waits for its acceptance; the gap comes first so
  // that valid stays high across back-to-back beats.
  task automatic send_triangle(in_beat_t b);
    int gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    planes.note_triangle(b);
    @(negedge clk_i);
  endtask

  // Waits for every plane to drain, then writes the threshold over the port.
  task automatic write_min_length(logic [15:0] v);
    in_valid_i <= 1'b0;
    while (planes.planes_due.size() != 0) @(negedge clk_i);
    repeat (Latency) @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= PaddrW'(RegMinLength) << 2;
    pwdata <= ApbDataW'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    planes.min_len = v;
  endtask

  function automatic coord_t any_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'(24'h7FFFFF);
      1: return coord_t'(24'h800000);
      2: return coord_t'($urandom_range(0, 600)) - coord_t'(300);
      default: return coord_t'($urandom());
    endcase
  endfunction

  // Mostly general triangles; some nearly collinear ones near the threshold.
  function automatic in_beat_t any_triangle();
    in_beat_t b;
    b = {any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
         any_coord(), any_coord(), any_coord(), any_coord()};
    if ($urandom_range(0, 4) == 0) begin
      b.p1_x = b.p0_x + coord_t'($urandom_range(0, 8)) - 4;
      b.p1_y = b.p0_y + coord_t'($urandom_range(0, 8)) - 4;
      b.p1_z = b.p0_z + coord_t'($urandom_range(0, 8)) - 4;
      b.p2_x = b.p0_x + coord_t'($urandom_range(0, 8)) - 4;
      b.p2_y = b.p0_y + coord_t'($urandom_range(0, 8)) - 4;
      b.p2_z = b.p0_z + coord_t'($urandom_range(0, 8)) - 4;
    end
    return b;
  endfunction

  // Receiver: random stall per beat, and one long hold-off on request.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (1000) @(negedge clk_i);
        hold_off = 1'b0;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Compare planes at the edge where they are accepted.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) planes.check_plane(out_beat_o);
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    in_beat_t b;
    logic [15:0] thresholds[5];
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes, collinear and coincident points, degenerate edge.
    send_triangle('0);
    send_triangle({9{coord_t'(24'h7FFFFF)}});
    send_triangle({9{coord_t'(24'h800000)}});
    b = '0; b.p1_x = 24'h7FFFFF; b.p2_y = 24'h7FFFFF;
    send_triangle(b);
    b = '0; b.p0_z = 24'h7FFFFF; b.p1_x = 24'h800000; b.p2_y = 24'h800000;
    send_triangle(b);
    b = '0; b.p0_x = 24'h800000; b.p0_y = 24'h800000; b.p0_z = 24'h800000;
    b.p1_x = 24'h7FFFFF; b.p2_y = 24'h7FFFFF;
    send_triangle(b);
    b = '0; b.p1_x = 2; b.p2_x = 4;
    send_triangle(b);
    // Cross length 66 exactly, then 67: either side of the reset threshold.
    b = '0; b.p1_x = 1; b.p2_y = 66;
    send_triangle(b);
    b.p2_y = 67;
    send_triangle(b);
    b = '0; b.p1_x = 24'h7FFFFF; b.p1_y = 24'h800000; b.p2_z = 24'h7FFFFF;
    b.p0_x = 24'h7FFFFF;
    send_triangle(b);
    for (int i = 0; i < 10; i++) send_triangle(any_triangle());

    thresholds = '{16'd0, 16'hFFFF, 16'd1, 16'd1000, 16'd66};
    for (int ph = 0; ph < 5; ph++) begin
      write_min_length(thresholds[ph]);
      for (int i = 0; i < 220; i++) begin
        if (ph == 1 && i == 20) hold_off = 1'b1;
        send_triangle(any_triangle());
      end
    end
    in_valid_i <= 1'b0;

    while (planes.planes_due.size() != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
    if (planes.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
